FILE: hdl/lftn_pkg.sv
`timescale 1ns / 1ps

package lftn_pkg;

    // Table and frame geometry.
    localparam int ENTRIES     = 60;
    localparam int FRAME_BYTES = 42;

    // Byte values of the frame format.
    localparam logic [7:0]  SYNC_BYTE    = 8'hFA;
    localparam logic [7:0]  INDEX_BASE   = 8'hA0;
    localparam logic [15:0] NO_RANGE     = 16'hFFFF;
    localparam logic [15:0] THRESH_RESET = 16'd10;

    // Operation codes.
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_RX_ENABLE = 1'b1;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic [5:0] range_start;
        logic [5:0] range_end;
    } item_t;

    typedef struct packed {
        logic signed [6:0] bearing;
        logic [15:0]       distance;
        logic [15:0]       intensity;
    } result_t;

endpackage

FILE: hdl/lidar_frame_table_nearest.sv
`timescale 1ns / 1ps

// Lidar frame decoder with a per-bearing range table and a nearest-bearing search.
// An item is taken when start is high and busy is low; results appear for one cycle
// with result_valid high and cannot be held off. A frame byte is absorbed in the cycle
// it is taken and gives no result. A read uses the table memory's registered read
// port, so busy is high for one cycle and the result shows on the cycle busy falls.
// A query walks the range through the same read port, one bearing per cycle, each
// compared once its registered read returns: busy stays high until the bearing before
// end, end clamped to 60, is compared, and the result shows on the cycle busy falls;
// an empty range answers -1 on the next cycle without raising busy. Both tables are
// ready straight after reset, as entries never written read as the reset values.
module lidar_frame_table_nearest (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  lftn_pkg::item_t  item,
    output logic             result_valid,
    output lftn_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data
);
    import lftn_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ
    } state_t;

    state_t state_reg;

    logic [15:0] thresh_reg;
    logic        rx_en_reg;
    logic [5:0]  pos_reg;
    logic        synced_reg;
    logic [7:0]  cap_idx_reg;
    logic [15:0] cap_int_reg;
    logic [15:0] cap_dist_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [15:0] dist_mem [ENTRIES];
    logic [15:0] int_mem [ENTRIES];
    logic [15:0] dist_rd_reg;
    logic [15:0] int_rd_reg;
    logic        vld_rd_reg;

    logic [5:0]        idx_reg;
    logic [5:0]        cmp_idx_reg;
    logic [5:0]        end_reg;
    logic signed [6:0] best_reg;
    logic [15:0]       shortest_reg;

    logic              result_valid_reg;
    result_t           result_reg;

    logic        accept;
    logic [5:0]  end_clamp;
    logic        q_empty;
    logic        rd_en;
    logic [5:0]  rd_addr;
    logic        frame_last;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [15:0] wr_dist;
    logic [15:0] scan_dist;
    logic        scan_take;
    logic signed [6:0] best_next;
    logic [15:0] shortest_next;
    logic        scan_last;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = !busy;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign accept    = start && !busy;
    assign end_clamp = (item.range_end > 6'(ENTRIES)) ? 6'(ENTRIES) : item.range_end;
    assign q_empty   = (item.range_start >= end_clamp);

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((item.op == OP_QUERY && !q_empty) ||
                               (item.op == OP_READ && item.range_start < 6'(ENTRIES))))
                begin
                    rd_en   = 1'b1;
                    rd_addr = item.range_start;
                end
            end
            ST_SCAN:
            begin
                rd_en = (idx_reg < end_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // The last byte of a synced frame whose index lies inside the table commits the captured fields to the tables.
    assign frame_last = (({1'b0, pos_reg} + 7'd1) >= 7'(FRAME_BYTES));
    assign wr_en      = accept && (item.op == OP_FRAME) && rx_en_reg && frame_last &&
                        synced_reg && (cap_idx_reg < 8'(ENTRIES));
    assign wr_addr    = cap_idx_reg[5:0];
    assign wr_dist    = (cap_int_reg > thresh_reg) ? cap_dist_reg : NO_RANGE;

    // Compare stage of the search: read data belongs to cmp_idx_reg.
    assign scan_dist     = vld_rd_reg ? dist_rd_reg : NO_RANGE;
    assign scan_take     = (scan_dist < shortest_reg);
    assign best_next     = scan_take ? $signed({1'b0, cmp_idx_reg}) : best_reg;
    assign shortest_next = scan_take ? scan_dist : shortest_reg;
    assign scan_last     = (({1'b0, cmp_idx_reg} + 7'd1) == {1'b0, end_reg});

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wr_addr] <= wr_dist;
            int_mem[wr_addr]  <= cap_int_reg;
        end
        if (rd_en)
        begin
            dist_rd_reg <= dist_mem[rd_addr];
            int_rd_reg  <= int_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            thresh_reg       <= THRESH_RESET;
            rx_en_reg        <= 1'b0;
            pos_reg          <= '0;
            synced_reg       <= 1'b0;
            cap_idx_reg      <= '0;
            cap_int_reg      <= '0;
            cap_dist_reg     <= '0;
            valid_reg        <= '0;
            vld_rd_reg       <= 1'b0;
            idx_reg          <= '0;
            cmp_idx_reg      <= '0;
            end_reg          <= '0;
            best_reg         <= '0;
            shortest_reg     <= NO_RANGE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            vld_rd_reg       <= rd_en && valid_reg[rd_addr];

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD:
                    begin
                        thresh_reg <= cfg_data;
                    end
                    REG_RX_ENABLE:
                    begin
                        rx_en_reg  <= cfg_data[0];
                        pos_reg    <= '0;
                        synced_reg <= 1'b0;
                    end
                    default:
                    begin
                        thresh_reg <= thresh_reg;
                    end
                endcase
            end

            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (item.op)
                            OP_FRAME:
                            begin
                                if (rx_en_reg)
                                begin
                                    case (pos_reg)
                                        6'd0: synced_reg <= (item.data_byte == SYNC_BYTE);
                                        6'd1: cap_idx_reg <= item.data_byte - INDEX_BASE;
                                        6'd4: cap_int_reg[7:0]   <= item.data_byte;
                                        6'd5: cap_int_reg[15:8]  <= item.data_byte;
                                        6'd6: cap_dist_reg[7:0]  <= item.data_byte;
                                        6'd7: cap_dist_reg[15:8] <= item.data_byte;
                                        default: ;
                                    endcase
                                    pos_reg <= frame_last ? 6'd0 : pos_reg + 6'd1;
                                end
                            end
                            OP_QUERY:
                            begin
                                if (q_empty)
                                begin
                                    result_valid_reg <= 1'b1;
                                    result_reg       <= '{bearing: -7'sd1,
                                                          distance: 16'd0,
                                                          intensity: 16'd0};
                                end
                                else
                                begin
                                    cmp_idx_reg  <= item.range_start;
                                    idx_reg      <= item.range_start + 6'd1;
                                    end_reg      <= end_clamp;
                                    best_reg     <= -7'sd1;
                                    shortest_reg <= NO_RANGE;
                                    state_reg    <= ST_SCAN;
                                end
                            end
                            OP_READ:
                            begin
                                cmp_idx_reg <= item.range_start;
                                state_reg   <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (scan_last)
                    begin
                        result_valid_reg <= 1'b1;
                        result_reg       <= '{bearing: best_next,
                                              distance: 16'd0,
                                              intensity: 16'd0};
                        state_reg        <= ST_IDLE;
                    end
                    else
                    begin
                        best_reg     <= best_next;
                        shortest_reg <= shortest_next;
                        cmp_idx_reg  <= idx_reg;
                        idx_reg      <= idx_reg + 6'd1;
                    end
                end
                ST_READ:
                begin
                    // An entry never written, or outside the table, reads as reset.
                    result_valid_reg <= 1'b1;
                    result_reg       <= '{bearing: $signed({1'b0, cmp_idx_reg}),
                                          distance: vld_rd_reg ? dist_rd_reg : NO_RANGE,
                                          intensity: vld_rd_reg ? int_rd_reg : 16'd0};
                    state_reg        <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/lftn_checker.sv
`timescale 1ns / 1ps

module lftn_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input lftn_pkg::item_t   item,
    input logic              result_valid,
    input lftn_pkg::result_t result,
    input logic              cfg_ready
);
    import lftn_pkg::*;

    // A result is only ever shown once the block has gone idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    // Frame bytes never produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_FRAME) |=> !result_valid)
        else $error("frame byte produced a result");

    // A read holds busy for one cycle and then echoes its index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.op == OP_READ) |=> busy ##1
            (result_valid && result.bearing == $signed({1'b0, $past(item.range_start, 2)})))
        else $error("read transfer did not complete as expected");

    // A query answer with bearing -1 carries no distance or intensity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.bearing[6]) |->
            (result.distance == 16'd0 && result.intensity == 16'd0))
        else $error("query result has non-zero payload");

    // Configuration is refused while an item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready)
        else $error("configuration accepted while busy");

endmodule

bind lidar_frame_table_nearest lftn_checker u_lftn_checker (.*);
